FILE: rtl/pnve_pkg.sv
`timescale 1ns / 1ps
// Package for the polyline nearest-vertex editor: sizes, operation codes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
package pnve_pkg;

    // Storage sizing.
    localparam int MAX_VERTS = 64;
    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int COORD_W   = 32;
    localparam int VERT_W    = 3 * COORD_W;

    // Operation codes carried by an item.
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_ALTER  = 3'd1,
        OP_DELETE = 3'd2,
        OP_INSERT = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_QVERT  = 3'd5,
        OP_QSEG   = 3'd6
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One datapath step per cycle.
    typedef enum logic [4:0] {
        DP_NOP,
        DP_VLOAD,
        DP_VSQX,
        DP_VSQY,
        DP_VCMP,
        DP_ALOAD,
        DP_BLOAD,
        DP_SQEX,
        DP_SQEY,
        DP_DOTX,
        DP_DOTY,
        DP_TDEC,
        DP_TDIV,
        DP_PRJX,
        DP_PRJY,
        DP_RESY,
        DP_SQRX,
        DP_SQRY,
        DP_SCMP
    } dp_op_t;

    // Source of a vertex write.
    typedef enum logic [1:0] {
        WR_MEMQ,
        WR_POINT,
        WR_POINT_NOZ
    } wr_src_t;

    // Update of the vertex count.
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    // Controller to datapath.
    typedef struct packed {
        dp_op_t             op;
        logic               latch;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        wr_src_t            wr_src;
        logic               b_first;
        logic               first;
        logic [IDX_W-1:0]   cand_idx;
        cnt_op_t            cnt_op;
        logic               res_load;
        logic               res_best;
        logic [1:0]         res_status;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   best_idx;
        logic               need_div;
    } dp_sts_t;

endpackage

FILE: rtl/polyline_nearest_vertex_editor_top.sv
`timescale 1ns / 1ps
// Append, clear, dropped or empty items finish without a scan; vertex ops scan
// all N vertices, then alter writes the point and delete shifts later vertices;
// segment ops scan every segment, with a bit-serial division when the ratio is
// fractional, and insert then shifts later vertices and writes the point.
// One item at a time through the shared multiplier; results cannot be stalled.
// Asynchronous active-low reset empties the list; vertex memory is not cleared.
module polyline_nearest_vertex_editor_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          op,
    input  logic signed [pnve_pkg::COORD_W-1:0] x_coord,
    input  logic signed [pnve_pkg::COORD_W-1:0] y_coord,
    input  logic signed [pnve_pkg::COORD_W-1:0] z_value,
    output logic                                done,
    output logic [pnve_pkg::IDX_W-1:0]          found_index,
    output logic [pnve_pkg::CNT_W-1:0]          vertex_count,
    output logic [1:0]                          status
);

    pnve_pkg::dp_cmd_t cmd;
    pnve_pkg::dp_sts_t sts;

    // Sequencer.
    pnve_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Storage and arithmetic.
    pnve_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_value      (z_value),
        .found_index  (found_index),
        .vertex_count (vertex_count),
        .status       (status)
    );

endmodule

FILE: rtl/pnve_dpath.sv
`timescale 1ns / 1ps
// Datapath of the polyline editor: vertex memory, vertex count, one shared
// multiplier, distance accumulation, bit-serial divider and best tracking.
// Depends on pnve_pkg.
module pnve_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pnve_pkg::dp_cmd_t                   cmd,
    output pnve_pkg::dp_sts_t                   sts,
    input  logic signed [pnve_pkg::COORD_W-1:0] x_coord,
    input  logic signed [pnve_pkg::COORD_W-1:0] y_coord,
    input  logic signed [pnve_pkg::COORD_W-1:0] z_value,
    output logic [pnve_pkg::IDX_W-1:0]          found_index,
    output logic [pnve_pkg::CNT_W-1:0]          vertex_count,
    output logic [1:0]                          status
);

    // Vertex memory, x in the low word, then y, then z.
    logic [pnve_pkg::VERT_W-1:0] mem [pnve_pkg::MAX_VERTS];
    logic [pnve_pkg::VERT_W-1:0] mem_q;
    logic [pnve_pkg::VERT_W-1:0] wr_data;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [29:0] qax_reg, qay_reg, qbx_reg, qby_reg, qfx_reg, qfy_reg;
    logic signed [30:0] ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [65:0] prod_reg;
    logic [64:0]        dist_reg, best_reg;
    logic [pnve_pkg::IDX_W-1:0] best_idx_reg;
    logic [61:0]        len_reg, rem_reg;
    logic signed [62:0] dot_reg;
    logic [16:0]        t_reg;
    logic               need_div_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [pnve_pkg::CNT_W-1:0] count_reg;
    logic [pnve_pkg::IDX_W-1:0] res_idx_reg;
    logic [1:0]         res_stat_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] mq_x, mq_y;
    logic signed [29:0] qpx, qpy, bx, by;
    logic [30:0]        abs_ex, abs_ey;
    logic [64:0]        cand_d;
    logic signed [62:0] dsum;
    logic               d_pos;
    logic [62:0]        rem2;
    logic [29:0]        proj_mag;
    logic signed [30:0] proj;

    assign mq_x = mem_q[31:0];
    assign mq_y = mem_q[63:32];
    assign qpx  = px_reg[31:2];
    assign qpy  = py_reg[31:2];
    assign bx   = cmd.b_first ? qfx_reg : mq_x[31:2];
    assign by   = cmd.b_first ? qfy_reg : mq_y[31:2];
    assign abs_ex = ex_reg[30] ? 31'(-ex_reg) : 31'(ex_reg);
    assign abs_ey = ey_reg[30] ? 31'(-ey_reg) : 31'(ey_reg);
    assign cand_d = dist_reg + {1'b0, prod_reg[63:0]};
    assign dsum   = dot_reg + $signed(prod_reg[62:0]);
    assign d_pos  = !dsum[62] && (dsum != 63'sd0);
    assign rem2   = {rem_reg, 1'b0};
    assign proj_mag = prod_reg[45:16];

    // Sign of the projection follows the sign of the edge component.
    always_comb
    begin
        if (cmd.op == pnve_pkg::DP_PRJY)
        begin
            proj = ex_reg[30] ? -$signed({1'b0, proj_mag}) : $signed({1'b0, proj_mag});
        end
        else
        begin
            proj = ey_reg[30] ? -$signed({1'b0, proj_mag}) : $signed({1'b0, proj_mag});
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            pnve_pkg::DP_VSQX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            pnve_pkg::DP_VSQY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            pnve_pkg::DP_SQEX:
            begin
                mul_a = 33'(ex_reg);
                mul_b = 33'(ex_reg);
            end
            pnve_pkg::DP_SQEY:
            begin
                mul_a = 33'(ey_reg);
                mul_b = 33'(ey_reg);
            end
            pnve_pkg::DP_DOTX:
            begin
                mul_a = 33'(wx_reg);
                mul_b = 33'(ex_reg);
            end
            pnve_pkg::DP_DOTY:
            begin
                mul_a = 33'(wy_reg);
                mul_b = 33'(ey_reg);
            end
            pnve_pkg::DP_PRJX:
            begin
                mul_a = $signed({2'b00, abs_ex});
                mul_b = $signed({16'b0, t_reg});
            end
            pnve_pkg::DP_PRJY:
            begin
                mul_a = $signed({2'b00, abs_ey});
                mul_b = $signed({16'b0, t_reg});
            end
            pnve_pkg::DP_SQRX:
            begin
                mul_a = 33'(rx_reg);
                mul_b = 33'(rx_reg);
            end
            pnve_pkg::DP_SQRY:
            begin
                mul_a = 33'(ry_reg);
                mul_b = 33'(ry_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Write data selection.
    always_comb
    begin
        unique case (cmd.wr_src)
            pnve_pkg::WR_POINT:     wr_data = {pz_reg, py_reg, px_reg};
            pnve_pkg::WR_POINT_NOZ: wr_data = {32'b0, py_reg, px_reg};
            default:                wr_data = mem_q;
        endcase
    end

    // Vertex memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q <= mem[cmd.rd_addr];
        end
    end

    // Vertex count and division flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            need_div_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.cnt_op)
                pnve_pkg::CNT_INC: count_reg <= count_reg + 1'b1;
                pnve_pkg::CNT_DEC: count_reg <= count_reg - 1'b1;
                pnve_pkg::CNT_CLR: count_reg <= '0;
                default:           count_reg <= count_reg;
            endcase
            if (cmd.op == pnve_pkg::DP_TDEC)
            begin
                need_div_reg <= (len_reg != 62'd0) && d_pos && (dsum[61:0] < len_reg);
            end
        end
    end

    // Arithmetic steps.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.latch)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
            pz_reg <= z_value;
        end
        if (cmd.res_load)
        begin
            res_idx_reg  <= cmd.res_best ? best_idx_reg : '0;
            res_stat_reg <= cmd.res_status;
        end
        unique case (cmd.op)
            pnve_pkg::DP_VLOAD:
            begin
                dx_reg <= 33'(mq_x) - 33'(px_reg);
                dy_reg <= 33'(mq_y) - 33'(py_reg);
            end
            pnve_pkg::DP_VSQY, pnve_pkg::DP_SQRY:
            begin
                dist_reg <= {1'b0, prod_reg[63:0]};
            end
            pnve_pkg::DP_VCMP:
            begin
                if (cmd.first || (cand_d < best_reg))
                begin
                    best_reg     <= cand_d;
                    best_idx_reg <= cmd.cand_idx;
                end
            end
            pnve_pkg::DP_SCMP:
            begin
                if (cmd.first || (cand_d < best_reg))
                begin
                    best_reg     <= cand_d;
                    best_idx_reg <= cmd.cand_idx;
                end
                qax_reg <= qbx_reg;
                qay_reg <= qby_reg;
            end
            pnve_pkg::DP_ALOAD:
            begin
                qax_reg <= mq_x[31:2];
                qay_reg <= mq_y[31:2];
                qfx_reg <= mq_x[31:2];
                qfy_reg <= mq_y[31:2];
            end
            pnve_pkg::DP_BLOAD:
            begin
                qbx_reg <= bx;
                qby_reg <= by;
                ex_reg  <= 31'(bx) - 31'(qax_reg);
                ey_reg  <= 31'(by) - 31'(qay_reg);
                wx_reg  <= 31'(qpx) - 31'(qax_reg);
                wy_reg  <= 31'(qpy) - 31'(qay_reg);
            end
            pnve_pkg::DP_SQEY:
            begin
                len_reg <= prod_reg[61:0];
            end
            pnve_pkg::DP_DOTX:
            begin
                len_reg <= len_reg + prod_reg[61:0];
            end
            pnve_pkg::DP_DOTY:
            begin
                dot_reg <= prod_reg[62:0];
            end
            pnve_pkg::DP_TDEC:
            begin
                rem_reg <= dsum[61:0];
                if ((len_reg != 62'd0) && d_pos && (dsum[61:0] >= len_reg))
                begin
                    t_reg <= 17'h10000;
                end
                else
                begin
                    t_reg <= '0;
                end
            end
            pnve_pkg::DP_TDIV:
            begin
                if (need_div_reg)
                begin
                    if (rem2 >= {1'b0, len_reg})
                    begin
                        rem_reg <= 62'(rem2 - {1'b0, len_reg});
                        t_reg   <= {t_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2[61:0];
                        t_reg   <= {t_reg[15:0], 1'b0};
                    end
                end
            end
            pnve_pkg::DP_PRJY:
            begin
                rx_reg <= 32'(wx_reg) - 32'(proj);
            end
            pnve_pkg::DP_RESY:
            begin
                ry_reg <= 32'(wy_reg) - 32'(proj);
            end
            default:
            begin
            end
        endcase
    end

    assign sts.count    = count_reg;
    assign sts.best_idx = best_idx_reg;
    assign sts.need_div = need_div_reg;

    assign found_index  = res_idx_reg;
    assign vertex_count = count_reg;
    assign status       = res_stat_reg;

endmodule

FILE: rtl/pnve_ctrl.sv
`timescale 1ns / 1ps
// Controller of the polyline editor: decodes an item and sequences the
// search scans, shifts and writes of the datapath. Depends on pnve_pkg.
module pnve_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        op,
    output logic              busy,
    output logic              done,
    output pnve_pkg::dp_cmd_t cmd,
    input  pnve_pkg::dp_sts_t sts
);

    typedef enum logic [24:0] {
        S_IDLE   = 25'h0000001,
        S_DECODE = 25'h0000002,
        S_V_LOAD = 25'h0000004,
        S_V_SQX  = 25'h0000008,
        S_V_SQY  = 25'h0000010,
        S_V_CMP  = 25'h0000020,
        S_A_LOAD = 25'h0000040,
        S_B_LOAD = 25'h0000080,
        S_SQEX   = 25'h0000100,
        S_SQEY   = 25'h0000200,
        S_DOTX   = 25'h0000400,
        S_DOTY   = 25'h0000800,
        S_TDEC   = 25'h0001000,
        S_TDIV   = 25'h0002000,
        S_PRJX   = 25'h0004000,
        S_PRJY   = 25'h0008000,
        S_RESY   = 25'h0010000,
        S_SQRX   = 25'h0020000,
        S_SQRY   = 25'h0040000,
        S_S_CMP  = 25'h0080000,
        S_SETUP  = 25'h0100000,
        S_SH_RD  = 25'h0200000,
        S_SH_WR  = 25'h0400000,
        S_PUT    = 25'h0800000,
        S_FINISH = 25'h1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [2:0]                 op_reg, op_next;
    logic [pnve_pkg::CNT_W-1:0] i_reg, i_next;
    logic [3:0]                 k_reg, k_next;
    logic                       closing_reg, closing_next;
    logic [1:0]                 st_reg, st_next;
    logic                       use_best_reg, use_best_next;
    logic                       done_reg, done_next;

    logic [pnve_pkg::CNT_W:0]   count_ext, i_plus1, i_plus2, best_p1;
    logic [pnve_pkg::CNT_W-1:0] i_minus1;
    logic                       full;

    assign count_ext = {1'b0, sts.count};
    assign i_plus1   = {1'b0, i_reg} + (pnve_pkg::CNT_W + 1)'(1);
    assign i_plus2   = {1'b0, i_reg} + (pnve_pkg::CNT_W + 1)'(2);
    assign i_minus1  = i_reg - 1'b1;
    assign best_p1   = (pnve_pkg::CNT_W + 1)'(sts.best_idx) + (pnve_pkg::CNT_W + 1)'(1);
    assign full      = count_ext >= (pnve_pkg::CNT_W + 1)'(pnve_pkg::MAX_VERTS);

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            closing_reg  <= 1'b0;
            st_reg       <= pnve_pkg::ST_DONE;
            use_best_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
            closing_reg  <= closing_next;
            st_reg       <= st_next;
            use_best_reg <= use_best_next;
            done_reg     <= done_next;
        end
    end

    // Next state and datapath command.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        closing_next  = closing_reg;
        st_next       = st_reg;
        use_best_next = use_best_reg;
        done_next     = 1'b0;

        cmd            = '0;
        cmd.op         = pnve_pkg::DP_NOP;
        cmd.wr_src     = pnve_pkg::WR_MEMQ;
        cmd.cnt_op     = pnve_pkg::CNT_HOLD;
        cmd.res_status = st_reg;
        cmd.res_best   = use_best_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    op_next    = op;
                    state_next = S_DECODE;
                end
            end

            // Pick the path of the operation from the current count.
            S_DECODE:
            begin
                st_next       = pnve_pkg::ST_DONE;
                use_best_next = 1'b0;
                state_next    = S_FINISH;
                case (op_reg)
                    pnve_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            st_next = pnve_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = sts.count[pnve_pkg::IDX_W-1:0];
                            cmd.wr_src  = pnve_pkg::WR_POINT;
                            cmd.cnt_op  = pnve_pkg::CNT_INC;
                        end
                    end
                    pnve_pkg::OP_INSERT:
                    begin
                        if (full)
                        begin
                            st_next = pnve_pkg::ST_FULL;
                        end
                        else if (sts.count <= pnve_pkg::CNT_W'(1))
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = sts.count[pnve_pkg::IDX_W-1:0];
                            cmd.wr_src  = pnve_pkg::WR_POINT_NOZ;
                            cmd.cnt_op  = pnve_pkg::CNT_INC;
                        end
                        else
                        begin
                            cmd.rd_en     = 1'b1;
                            use_best_next = 1'b1;
                            state_next    = S_A_LOAD;
                        end
                    end
                    pnve_pkg::OP_ALTER, pnve_pkg::OP_DELETE, pnve_pkg::OP_QVERT:
                    begin
                        if (sts.count == '0)
                        begin
                            st_next = pnve_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en     = 1'b1;
                            i_next        = '0;
                            use_best_next = 1'b1;
                            state_next    = S_V_LOAD;
                        end
                    end
                    pnve_pkg::OP_CLEAR:
                    begin
                        cmd.cnt_op = pnve_pkg::CNT_CLR;
                    end
                    pnve_pkg::OP_QSEG:
                    begin
                        if (sts.count == '0)
                        begin
                            st_next = pnve_pkg::ST_EMPTY;
                        end
                        else if (sts.count != pnve_pkg::CNT_W'(1))
                        begin
                            cmd.rd_en     = 1'b1;
                            use_best_next = 1'b1;
                            state_next    = S_A_LOAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Vertex scan: load, square x, square y, then compare, for each vertex.
            S_V_LOAD:
            begin
                cmd.op     = pnve_pkg::DP_VLOAD;
                state_next = S_V_SQX;
            end
            S_V_SQX:
            begin
                cmd.op     = pnve_pkg::DP_VSQX;
                state_next = S_V_SQY;
            end
            S_V_SQY:
            begin
                cmd.op     = pnve_pkg::DP_VSQY;
                state_next = S_V_CMP;
            end
            S_V_CMP:
            begin
                cmd.op       = pnve_pkg::DP_VCMP;
                cmd.first    = (i_reg == '0);
                cmd.cand_idx = i_reg[pnve_pkg::IDX_W-1:0];
                cmd.rd_en    = 1'b1;
                cmd.rd_addr  = i_plus1[pnve_pkg::IDX_W-1:0];
                i_next       = i_plus1[pnve_pkg::CNT_W-1:0];
                state_next   = (i_plus1 < count_ext) ? S_V_LOAD : S_SETUP;
            end

            // Segment scan: first vertex becomes the leading end.
            S_A_LOAD:
            begin
                cmd.op       = pnve_pkg::DP_ALOAD;
                cmd.rd_en    = 1'b1;
                cmd.rd_addr  = pnve_pkg::IDX_W'(1);
                i_next       = pnve_pkg::CNT_W'(1);
                closing_next = 1'b0;
                state_next   = S_B_LOAD;
            end
            S_B_LOAD:
            begin
                cmd.op      = pnve_pkg::DP_BLOAD;
                cmd.b_first = closing_reg;
                state_next  = S_SQEX;
            end
            S_SQEX:
            begin
                cmd.op     = pnve_pkg::DP_SQEX;
                state_next = S_SQEY;
            end
            S_SQEY:
            begin
                cmd.op     = pnve_pkg::DP_SQEY;
                state_next = S_DOTX;
            end
            S_DOTX:
            begin
                cmd.op     = pnve_pkg::DP_DOTX;
                state_next = S_DOTY;
            end
            S_DOTY:
            begin
                cmd.op     = pnve_pkg::DP_DOTY;
                state_next = S_TDEC;
            end
            S_TDEC:
            begin
                cmd.op     = pnve_pkg::DP_TDEC;
                k_next     = '0;
                state_next = S_TDIV;
            end
            // Sixteen quotient bits, one per cycle, when the ratio is fractional.
            S_TDIV:
            begin
                cmd.op = pnve_pkg::DP_TDIV;
                k_next = k_reg + 1'b1;
                if (!sts.need_div || (k_reg == 4'hf))
                begin
                    state_next = S_PRJX;
                end
            end
            S_PRJX:
            begin
                cmd.op     = pnve_pkg::DP_PRJX;
                state_next = S_PRJY;
            end
            S_PRJY:
            begin
                cmd.op     = pnve_pkg::DP_PRJY;
                state_next = S_RESY;
            end
            S_RESY:
            begin
                cmd.op     = pnve_pkg::DP_RESY;
                state_next = S_SQRX;
            end
            S_SQRX:
            begin
                cmd.op     = pnve_pkg::DP_SQRX;
                state_next = S_SQRY;
            end
            S_SQRY:
            begin
                cmd.op     = pnve_pkg::DP_SQRY;
                state_next = S_S_CMP;
            end
            // Compare, then move on to the next segment, the closing one, or the edit setup.
            S_S_CMP:
            begin
                cmd.op       = pnve_pkg::DP_SCMP;
                cmd.first    = (i_reg == pnve_pkg::CNT_W'(1)) && !closing_reg;
                cmd.cand_idx = i_minus1[pnve_pkg::IDX_W-1:0];
                if (closing_reg)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    i_next     = i_plus1[pnve_pkg::CNT_W-1:0];
                    state_next = S_B_LOAD;
                    if (i_plus1 < count_ext)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = i_plus1[pnve_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        closing_next = 1'b1;
                    end
                end
            end

            // Prepare the edit that follows a search.
            S_SETUP:
            begin
                state_next = S_FINISH;
                case (op_reg)
                    pnve_pkg::OP_DELETE:
                    begin
                        i_next = pnve_pkg::CNT_W'(sts.best_idx);
                        if (best_p1 < count_ext)
                        begin
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            cmd.cnt_op = pnve_pkg::CNT_DEC;
                        end
                    end
                    pnve_pkg::OP_INSERT:
                    begin
                        i_next     = sts.count;
                        state_next = (count_ext > best_p1) ? S_SH_RD : S_PUT;
                    end
                    pnve_pkg::OP_ALTER:
                    begin
                        state_next = S_PUT;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Shift one vertex: read its neighbor, then write it in place.
            S_SH_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = (op_reg == pnve_pkg::OP_DELETE) ?
                              i_plus1[pnve_pkg::IDX_W-1:0] : i_minus1[pnve_pkg::IDX_W-1:0];
                state_next  = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = i_reg[pnve_pkg::IDX_W-1:0];
                cmd.wr_src  = pnve_pkg::WR_MEMQ;
                if (op_reg == pnve_pkg::OP_DELETE)
                begin
                    i_next = i_plus1[pnve_pkg::CNT_W-1:0];
                    if (i_plus2 < count_ext)
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        cmd.cnt_op = pnve_pkg::CNT_DEC;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    i_next     = i_minus1;
                    state_next = ({1'b0, i_minus1} > best_p1) ? S_SH_RD : S_PUT;
                end
            end

            // Place the new point for insert or alter.
            S_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = pnve_pkg::WR_POINT;
                if (op_reg == pnve_pkg::OP_INSERT)
                begin
                    cmd.wr_addr = best_p1[pnve_pkg::IDX_W-1:0];
                    cmd.cnt_op  = pnve_pkg::CNT_INC;
                end
                else
                begin
                    cmd.wr_addr = sts.best_idx;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                cmd.res_load = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted item makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // The count never grows past capacity.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == pnve_pkg::CNT_INC) |-> !full)
        else $error("count incremented while full");

    // Memory writes only happen in the edit states.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == S_DECODE || state_reg == S_SH_WR || state_reg == S_PUT))
        else $error("vertex write outside an edit state");

endmodule
